FILE: rtl/core/edfs_pkg.sv
// ----------------------------------------------------------------------------
// edfs_pkg
// Shared constants and codes for the two-task EDF scheduler.
// ----------------------------------------------------------------------------
package edfs_pkg;

    localparam int TIME_BITS_DEF   = 16;
    localparam int PERIOD_BITS_DEF = 10;

    // field widths on the streams
    localparam int TIME_NOW_W = 16;
    localparam int TASK_W     = 2;
    localparam int S_DATA_W   = 8;
    localparam int M_DATA_W   = 24;

    // task codes on running_task
    localparam logic [TASK_W-1:0] TASK_IDLE = 2'd0;
    localparam logic [TASK_W-1:0] TASK_A    = 2'd1;
    localparam logic [TASK_W-1:0] TASK_B    = 2'd2;

    // configuration register indexes
    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] REG_PERIOD_A = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_EXEC_A   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_PERIOD_B = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_EXEC_B   = 2'd3;

    // register reset values
    localparam int PERIOD_A_RST = 20;
    localparam int EXEC_A_RST   = 10;
    localparam int PERIOD_B_RST = 50;
    localparam int EXEC_B_RST   = 25;

    // bit positions in m_tdata
    localparam int M_RUN_LSB  = 16;
    localparam int M_REL_A    = 18;
    localparam int M_REL_B    = 19;
    localparam int M_DONE_A   = 20;
    localparam int M_DONE_B   = 21;
    localparam int M_OVERLOAD = 22;

endpackage

FILE: rtl/core/edf_two_task_scheduler.sv
// ----------------------------------------------------------------------------
// edf_two_task_scheduler
// Tick-driven earliest-deadline-first scheduler for two periodic tasks.
// ----------------------------------------------------------------------------
//  channel   dir  handshake          payload
//  s_*       in   tvalid/tready      tdata[0] restart
//  m_*       out  tvalid/tready      tdata: time_now, running_task, released_a,
//                                    released_b, done_a, done_b, overload
//  cfg_*     in   cfg_we             cfg_index, cfg_wdata
//
//  one tick request is taken every clock while the output is not stalled; a
//  tick waits in the input register and its result is written into the
//  output register as it advances; load check products are registered
//  reset clears tick time, phases, work, deadlines, current task, valid flags
//  a stalled output holds; an empty input register still fills behind it
// ----------------------------------------------------------------------------
module edf_two_task_scheduler #(
    parameter int TIME_BITS   = edfs_pkg::TIME_BITS_DEF,
    parameter int PERIOD_BITS = edfs_pkg::PERIOD_BITS_DEF
) (
    input  logic                           clk,
    input  logic                           rst_n,
    // config write port
    input  logic                           cfg_we,
    input  logic [edfs_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [PERIOD_BITS-1:0]         cfg_wdata,
    // tick requests
    input  logic                           s_tvalid,
    output logic                           s_tready,
    input  logic [edfs_pkg::S_DATA_W-1:0]  s_tdata,   // [0] restart
    // results
    output logic                           m_tvalid,
    input  logic                           m_tready,
    // [15:0] time_now, [17:16] running_task, [18] released_a, [19] released_b,
    // [20] done_a, [21] done_b, [22] overload, [23] zero
    output logic [edfs_pkg::M_DATA_W-1:0]  m_tdata
);

    localparam int PB = PERIOD_BITS;
    localparam int TW = edfs_pkg::TASK_W;

    // configuration registers
    logic [PB-1:0] period_a_reg, exec_a_reg, period_b_reg, exec_b_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            period_a_reg <= PB'(edfs_pkg::PERIOD_A_RST);
            exec_a_reg   <= PB'(edfs_pkg::EXEC_A_RST);
            period_b_reg <= PB'(edfs_pkg::PERIOD_B_RST);
            exec_b_reg   <= PB'(edfs_pkg::EXEC_B_RST);
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                edfs_pkg::REG_PERIOD_A: period_a_reg <= cfg_wdata;
                edfs_pkg::REG_EXEC_A:   exec_a_reg   <= cfg_wdata;
                edfs_pkg::REG_PERIOD_B: period_b_reg <= cfg_wdata;
                edfs_pkg::REG_EXEC_B:   exec_b_reg   <= cfg_wdata;
            endcase
        end
    end

    // zero period counts as one
    logic [PB-1:0] eff_pa, eff_pb;
    assign eff_pa = (period_a_reg == '0) ? PB'(1) : period_a_reg;
    assign eff_pb = (period_b_reg == '0) ? PB'(1) : period_b_reg;

    // load check products, one register stage
    logic [2*PB-1:0] prod_ea_reg, prod_eb_reg, prod_pp_reg;

    always_ff @(posedge clk)
    begin
        prod_ea_reg <= (2*PB)'(exec_a_reg) * (2*PB)'(eff_pb);
        prod_eb_reg <= (2*PB)'(exec_b_reg) * (2*PB)'(eff_pa);
        prod_pp_reg <= (2*PB)'(eff_pa) * (2*PB)'(eff_pb);
    end

    logic [2*PB:0] demand;
    logic          overload;
    assign demand   = {1'b0, prod_ea_reg} + {1'b0, prod_eb_reg};
    assign overload = demand > {1'b0, prod_pp_reg};

    // input register and output stage handshake
    logic in_valid_reg, in_restart_reg;
    logic out_valid_reg;
    logic advance;

    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (s_tready)
                in_valid_reg <= s_tvalid;
            if (advance)
                out_valid_reg <= 1'b1;
            else if (m_tready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tready && s_tvalid)
            in_restart_reg <= s_tdata[0];
    end

    // scheduler state
    logic [TIME_BITS-1:0] tick_reg;
    logic [PB-1:0]        phase_a_reg, phase_b_reg;
    logic [PB-1:0]        work_a_reg, work_b_reg;
    logic [PB-1:0]        dl_a_reg, dl_b_reg;
    logic [TW-1:0]        cur_reg;

    logic [TIME_BITS-1:0] tick_now, tick_next;
    logic [PB-1:0]        ph_a, ph_b, phase_a_next, phase_b_next;
    logic [PB-1:0]        wl_a, wl_b, work_a_next, work_b_next;
    logic [PB-1:0]        dl_a, dl_b, dl_a_next, dl_b_next;
    logic [TW-1:0]        cur, run;
    logic                 rel_a, rel_b, pend_a, pend_b, done_a, done_b;
    logic [PB:0]          ph_a_inc, ph_b_inc;

    always_comb
    begin
        tick_now = in_restart_reg ? '0 : tick_reg;
        ph_a     = in_restart_reg ? '0 : phase_a_reg;
        ph_b     = in_restart_reg ? '0 : phase_b_reg;
        cur      = in_restart_reg ? edfs_pkg::TASK_IDLE : cur_reg;

        rel_a = (ph_a == '0);
        rel_b = (ph_b == '0);
        wl_a  = rel_a ? exec_a_reg : work_a_reg;
        wl_b  = rel_b ? exec_b_reg : work_b_reg;
        dl_a  = rel_a ? eff_pa : dl_a_reg;
        dl_b  = rel_b ? eff_pb : dl_b_reg;

        pend_a = (wl_a != '0);
        pend_b = (wl_b != '0);
        run    = edfs_pkg::TASK_IDLE;
        if (!overload)
        begin
            if (pend_a && pend_b)
            begin
                if (dl_a < dl_b)
                    run = edfs_pkg::TASK_A;
                else if (dl_b < dl_a)
                    run = edfs_pkg::TASK_B;
                else if (rel_a && rel_b)
                    run = edfs_pkg::TASK_A;
                else
                    run = (cur == edfs_pkg::TASK_B) ? edfs_pkg::TASK_B : edfs_pkg::TASK_A;
            end
            else if (pend_a)
                run = edfs_pkg::TASK_A;
            else if (pend_b)
                run = edfs_pkg::TASK_B;
        end

        work_a_next = (run == edfs_pkg::TASK_A) ? wl_a - PB'(1) : wl_a;
        work_b_next = (run == edfs_pkg::TASK_B) ? wl_b - PB'(1) : wl_b;
        // zero-work release finishes at once, otherwise the last unit finishes
        done_a = (rel_a && !pend_a) || (run == edfs_pkg::TASK_A && wl_a == PB'(1));
        done_b = (rel_b && !pend_b) || (run == edfs_pkg::TASK_B && wl_b == PB'(1));

        dl_a_next = (dl_a != '0) ? dl_a - PB'(1) : dl_a;
        dl_b_next = (dl_b != '0) ? dl_b - PB'(1) : dl_b;

        ph_a_inc     = {1'b0, ph_a} + (PB+1)'(1);
        ph_b_inc     = {1'b0, ph_b} + (PB+1)'(1);
        phase_a_next = (ph_a_inc >= {1'b0, eff_pa}) ? '0 : ph_a_inc[PB-1:0];
        phase_b_next = (ph_b_inc >= {1'b0, eff_pb}) ? '0 : ph_b_inc[PB-1:0];

        tick_next = tick_now + TIME_BITS'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tick_reg    <= '0;
            phase_a_reg <= '0;
            phase_b_reg <= '0;
            work_a_reg  <= '0;
            work_b_reg  <= '0;
            dl_a_reg    <= '0;
            dl_b_reg    <= '0;
            cur_reg     <= edfs_pkg::TASK_IDLE;
        end
        else if (advance)
        begin
            tick_reg    <= tick_next;
            phase_a_reg <= phase_a_next;
            phase_b_reg <= phase_b_next;
            work_a_reg  <= work_a_next;
            work_b_reg  <= work_b_next;
            dl_a_reg    <= dl_a_next;
            dl_b_reg    <= dl_b_next;
            cur_reg     <= run;
        end
    end

    // result register
    logic [TIME_BITS+edfs_pkg::TIME_NOW_W-1:0] tick_ext;
    logic [edfs_pkg::M_DATA_W-1:0]             out_data_reg;

    assign tick_ext = {{edfs_pkg::TIME_NOW_W{1'b0}}, tick_now};

    always_ff @(posedge clk)
    begin
        if (advance)
            out_data_reg <= {1'b0, overload, done_b, done_a, rel_b, rel_a, run,
                             tick_ext[edfs_pkg::TIME_NOW_W-1:0]};
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

endmodule

FILE: rtl/core/edfs_checker.sv
// ----------------------------------------------------------------------------
// edfs_checker
// Port-level checks for the two-task EDF scheduler, bound to the top level.
// ----------------------------------------------------------------------------
module edfs_checker (
    input logic                          clk,
    input logic                          rst_n,
    input logic                          m_tvalid,
    input logic                          m_tready,
    input logic [edfs_pkg::M_DATA_W-1:0] m_tdata
);

    logic [edfs_pkg::TASK_W-1:0] run;
    assign run = m_tdata[edfs_pkg::M_RUN_LSB +: edfs_pkg::TASK_W];

    // a stalled result holds
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result changed while stalled");

    a_code: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> run == edfs_pkg::TASK_IDLE || run == edfs_pkg::TASK_A
                     || run == edfs_pkg::TASK_B)
        else $error("bad running task code");

    // overload runs nothing
    a_ovl: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tdata[edfs_pkg::M_OVERLOAD] |-> run == edfs_pkg::TASK_IDLE)
        else $error("task run under overload");

    // without a release, completion only comes from running the task
    a_done_a: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tdata[edfs_pkg::M_DONE_A] && !m_tdata[edfs_pkg::M_REL_A]
        |-> run == edfs_pkg::TASK_A)
        else $error("task a done without running");

    a_done_b: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tdata[edfs_pkg::M_DONE_B] && !m_tdata[edfs_pkg::M_REL_B]
        |-> run == edfs_pkg::TASK_B)
        else $error("task b done without running");

endmodule

bind edf_two_task_scheduler edfs_checker u_edfs_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

FILE: tb/tb_edf_two_task_scheduler.sv
// ----------------------------------------------------------------------------
// tb_edf_two_task_scheduler
// Self-checking bench for the two-task EDF scheduler: tick requests go in
// from a queue, every accepted tick is scheduled again by a predictor in the
// bench, and each returned result is compared field by field. Task loads are
// rewritten between phases while the block is idle, and both sides stall at
// random.
// ----------------------------------------------------------------------------
module tb_edf_two_task_scheduler;

    localparam int PW          = edfs_pkg::PERIOD_BITS_DEF;
    localparam int STUCK_LIMIT = 2000;
    localparam int RAND_PHASES = 12;
    localparam int PHASE_TICKS = 52;
    localparam int HOLD_AT     = 200;
    localparam int HOLD_CYCLES = 60;

    // result word as it sits on m_tdata, msb first
    typedef struct packed {
        logic                            pad;
        logic                            overload;
        logic                            done_b;
        logic                            done_a;
        logic                            rel_b;
        logic                            rel_a;
        logic [edfs_pkg::TASK_W-1:0]     run_task;
        logic [edfs_pkg::TIME_NOW_W-1:0] time_now;
    } tick_result_t;

    logic                           clk       = 1'b0;
    logic                           rst_n     = 1'b0;
    logic                           cfg_we    = 1'b0;
    logic [edfs_pkg::CFG_IDX_W-1:0] cfg_index = '0;
    logic [PW-1:0]                  cfg_wdata = '0;
    logic                           s_tvalid  = 1'b0;
    wire                            s_tready;
    logic [edfs_pkg::S_DATA_W-1:0]  s_tdata   = '0;   // [0] restart
    wire                            m_tvalid;
    logic                           m_tready  = 1'b0;
    // [15:0] time_now, [17:16] running_task, [18] released_a, [19] released_b,
    // [20] done_a, [21] done_b, [22] overload, [23] zero
    wire  [edfs_pkg::M_DATA_W-1:0]  m_tdata;

    // task loads as last written
    logic [PW-1:0] per_a = PW'(edfs_pkg::PERIOD_A_RST);
    logic [PW-1:0] exe_a = PW'(edfs_pkg::EXEC_A_RST);
    logic [PW-1:0] per_b = PW'(edfs_pkg::PERIOD_B_RST);
    logic [PW-1:0] exe_b = PW'(edfs_pkg::EXEC_B_RST);
    logic          overloaded = 1'b0;

    // scheduler state
    logic [edfs_pkg::TIME_NOW_W-1:0] tick_now = '0;
    logic [PW-1:0]                   phase_a  = '0;
    logic [PW-1:0]                   phase_b  = '0;
    logic [PW-1:0]                   work_a   = '0;
    logic [PW-1:0]                   work_b   = '0;
    logic [PW-1:0]                   dl_a     = '0;
    logic [PW-1:0]                   dl_b     = '0;
    logic [edfs_pkg::TASK_W-1:0]     last_run = edfs_pkg::TASK_IDLE;

    bit           tick_reqs[$];
    tick_result_t schedule_log[$];

    int tx_idle_pct  = 37;
    int rx_idle_pct  = 51;
    int err_count    = 0;
    int results_seen = 0;
    int hold_left    = 0;
    bit held_once    = 1'b0;
    int stuck_cycles = 0;

    edf_two_task_scheduler DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    function automatic logic [PW-1:0] eff_period(input logic [PW-1:0] p);
        return (p == '0) ? PW'(1) : p;
    endfunction

    function automatic logic [PW-1:0] next_phase(input logic [PW-1:0] ph,
                                                 input logic [PW-1:0] p);
        return (int'(ph) + 1 >= int'(eff_period(p))) ? '0 : ph + 1'b1;
    endfunction

    // one scheduler tick: release, pick the earlier deadline, burn one unit
    function automatic tick_result_t schedule_tick(input logic restart);
        tick_result_t  r;
        logic          rel_a;
        logic          rel_b;
        logic          fin_a;
        logic          fin_b;
        logic [edfs_pkg::TASK_W-1:0] pick;
        r     = '0;
        fin_a = 1'b0;
        fin_b = 1'b0;
        pick  = edfs_pkg::TASK_IDLE;
        if (restart)
        begin
            tick_now = '0;
            phase_a  = '0;
            phase_b  = '0;
            last_run = edfs_pkg::TASK_IDLE;
        end
        rel_a = (phase_a == '0);
        rel_b = (phase_b == '0);
        if (rel_a)
        begin
            work_a = exe_a;
            dl_a   = eff_period(per_a);
            if (work_a == '0)
                fin_a = 1'b1;
        end
        if (rel_b)
        begin
            work_b = exe_b;
            dl_b   = eff_period(per_b);
            if (work_b == '0)
                fin_b = 1'b1;
        end
        if (!overloaded)
        begin
            if (work_a != '0 && work_b != '0)
            begin
                if (dl_a < dl_b)
                    pick = edfs_pkg::TASK_A;
                else if (dl_b < dl_a)
                    pick = edfs_pkg::TASK_B;
                else if (rel_a && rel_b)
                    pick = edfs_pkg::TASK_A;
                else
                    pick = (last_run == edfs_pkg::TASK_B) ? edfs_pkg::TASK_B
                                                          : edfs_pkg::TASK_A;
            end
            else if (work_a != '0)
                pick = edfs_pkg::TASK_A;
            else if (work_b != '0)
                pick = edfs_pkg::TASK_B;
        end
        if (pick == edfs_pkg::TASK_A)
        begin
            work_a = work_a - 1'b1;
            if (work_a == '0)
                fin_a = 1'b1;
        end
        else if (pick == edfs_pkg::TASK_B)
        begin
            work_b = work_b - 1'b1;
            if (work_b == '0)
                fin_b = 1'b1;
        end
        last_run   = pick;
        r.time_now = tick_now;
        r.run_task = pick;
        r.rel_a    = rel_a;
        r.rel_b    = rel_b;
        r.done_a   = fin_a;
        r.done_b   = fin_b;
        r.overload = overloaded;
        if (dl_a != '0)
            dl_a = dl_a - 1'b1;
        if (dl_b != '0)
            dl_b = dl_b - 1'b1;
        phase_a  = next_phase(phase_a, per_a);
        phase_b  = next_phase(phase_b, per_b);
        tick_now = tick_now + 1'b1;
        return r;
    endfunction

    task automatic report(input string msg);
        $display("ERROR: %s", msg);
        err_count++;
    endtask

    task automatic compare(input string field, input int unsigned got,
                           input int unsigned want);
        if (got != want)
            report($sformatf("result %0d %s: got %0d, expected %0d",
                             results_seen, field, got, want));
    endtask

    // request driver
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (s_tvalid && s_tready)
                schedule_log.push_back(schedule_tick(s_tdata[0]));
            if (!s_tvalid || s_tready)
            begin
                if (tick_reqs.size() != 0 && $urandom_range(99) >= tx_idle_pct)
                begin
                    s_tvalid <= 1'b1;
                    s_tdata  <= {{(edfs_pkg::S_DATA_W-1){1'b0}}, tick_reqs.pop_front()};
                end
                else
                    s_tvalid <= 1'b0;
            end
        end
    end

    // result monitor and receiver stalls
    always @(posedge clk)
    begin
        tick_result_t got;
        tick_result_t want;
        if (rst_n)
        begin
            if (m_tvalid && m_tready)
            begin
                got = m_tdata;
                results_seen++;
                if (schedule_log.size() == 0)
                    report($sformatf("result %0d at time_now %0d with no tick pending",
                                     results_seen, got.time_now));
                else
                begin
                    want = schedule_log.pop_front();
                    compare("time_now", got.time_now, want.time_now);
                    compare("running_task", got.run_task, want.run_task);
                    compare("released_a", got.rel_a, want.rel_a);
                    compare("released_b", got.rel_b, want.rel_b);
                    compare("done_a", got.done_a, want.done_a);
                    compare("done_b", got.done_b, want.done_b);
                    compare("overload", got.overload, want.overload);
                    compare("pad bit", got.pad, want.pad);
                end
            end
            // one long hold-off so the input side backs up
            if (hold_left != 0)
            begin
                hold_left <= hold_left - 1;
                m_tready  <= 1'b0;
            end
            else if (results_seen == HOLD_AT && !held_once)
            begin
                held_once <= 1'b1;
                hold_left <= HOLD_CYCLES;
                m_tready  <= 1'b0;
            end
            else
                m_tready <= ($urandom_range(99) >= rx_idle_pct);
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready))
            stuck_cycles <= 0;
        else if (stuck_cycles == STUCK_LIMIT)
        begin
            $display("Some tests failed");
            $finish;
        end
        else
            stuck_cycles <= stuck_cycles + 1;
    end

    task automatic wait_idle();
        while (tick_reqs.size() != 0 || s_tvalid || schedule_log.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_reg(input logic [edfs_pkg::CFG_IDX_W-1:0] idx,
                             input logic [PW-1:0] val);
        int pa;
        int pb;
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        case (idx)
            edfs_pkg::REG_PERIOD_A: per_a = val;
            edfs_pkg::REG_EXEC_A:   exe_a = val;
            edfs_pkg::REG_PERIOD_B: per_b = val;
            edfs_pkg::REG_EXEC_B:   exe_b = val;
            default:                ;
        endcase
        pa = int'(eff_period(per_a));
        pb = int'(eff_period(per_b));
        overloaded = (int'(exe_a) * pb + int'(exe_b) * pa) > pa * pb;
    endtask

    task automatic load_tasks(input logic [PW-1:0] pa, input logic [PW-1:0] ea,
                              input logic [PW-1:0] pb, input logic [PW-1:0] eb);
        wait_idle();
        write_reg(edfs_pkg::REG_PERIOD_A, pa);
        write_reg(edfs_pkg::REG_EXEC_A, ea);
        write_reg(edfs_pkg::REG_PERIOD_B, pb);
        write_reg(edfs_pkg::REG_EXEC_B, eb);
        @(posedge clk);
        cfg_we <= 1'b0;
        // let the load check settle after the last write
        repeat (3) @(posedge clk);
    endtask

    task automatic push_ticks(input int n, input int restart_at);
        for (int i = 0; i < n; i++)
            tick_reqs.push_back(i == restart_at);
    endtask

    initial
    begin
        logic [PW-1:0] pa;
        logic [PW-1:0] ea;
        logic [PW-1:0] pb;
        logic [PW-1:0] eb;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;

        // reset loads, joint release from a restart
        push_ticks(6, 0);
        // zero period and zero work on A
        load_tasks(10'd0, 10'd0, 10'd3, 10'd1);
        push_ticks(4, -1);
        // equal deadlines, full utilization
        load_tasks(10'd4, 10'd2, 10'd4, 10'd2);
        push_ticks(5, 0);
        // overloaded: nothing runs, deadlines run out
        load_tasks(10'd1023, 10'd1023, 10'd1, 10'd1);
        push_ticks(3, -1);
        // period of A shrinks below its phase, B has no work
        load_tasks(10'd1, 10'd1, 10'd1023, 10'd0);
        push_ticks(3, 2);

        for (int p = 0; p < RAND_PHASES; p++)
        begin
            case ($urandom_range(7))
                0:
                begin
                    pa = PW'($urandom_range(1023));
                    ea = PW'($urandom_range(1023));
                    pb = PW'($urandom_range(1023));
                    eb = PW'($urandom_range(1023));
                end
                1:
                begin
                    pa = PW'($urandom_range(512, 1023));
                    ea = PW'($urandom_range(0, 40));
                    pb = PW'($urandom_range(1, 30));
                    eb = PW'($urandom_range(0, pb / 2));
                end
                default:
                begin
                    pa = PW'($urandom_range(0, 24));
                    ea = PW'($urandom_range(0, (eff_period(pa) + 1) / 2));
                    pb = PW'($urandom_range(0, 24));
                    eb = PW'($urandom_range(0, (eff_period(pb) + 1) / 2));
                end
            endcase
            load_tasks(pa, ea, pb, eb);
            if (p == RAND_PHASES / 3)
            begin
                tx_idle_pct = 51;
                rx_idle_pct = 37;
            end
            else if (p == 2 * RAND_PHASES / 3)
            begin
                tx_idle_pct = 0;
                rx_idle_pct = 0;
            end
            for (int k = 0; k < PHASE_TICKS; k++)
                tick_reqs.push_back($urandom_range(29) == 0);
        end

        wait_idle();
        if (err_count == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
